>>> rtl/core/aob_pkg.sv
// Shared types and constants for the alpha-over pixel blender.
// Used by the divider step and by the top level; depends on nothing else.
package aob_pkg;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PROD_W     = 2 * CH_W;
    localparam int NUM_W      = 3 * CH_W;
    localparam int DIVR_W     = PROD_W + 1;
    localparam int DIV_STEPS  = CH_W;
    localparam int PRE_STAGES = 3;
    localparam int NUM_STAGES = PRE_STAGES + DIV_STEPS;

    localparam int IN_DATA_W  = 8 * CH_W;
    localparam int OUT_DATA_W = 4 * CH_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    typedef logic [APB_ADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_BLEND_MODE = 1'b0;

    typedef enum logic {
        BLEND_REPLACE = 1'b0,
        BLEND_OVER    = 1'b1
    } t_blend_mode;

    // Partial remainder plus the shift register that holds the low dividend
    // bits not yet consumed and the quotient bits produced so far.
    typedef struct packed {
        logic [DIVR_W-1:0] rem;
        logic [CH_W-1:0]   lq;
    } t_div_ch;

    typedef struct packed {
        t_blend_mode              mode;
        logic                     a_zero;
        logic [DIVR_W-1:0]        divisor;
        t_div_ch [NUM_CH-1:0]     ch;
        logic [CH_W-1:0]          alpha;
        logic [NUM_CH*CH_W-1:0]   src_rgb;
    } t_div_item;

endpackage

>>> rtl/core/aob_div_step.sv
// One registered restoring-division step for the three colour channels.
// Depends on aob_pkg for the item type.
module aob_div_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  aob_pkg::t_div_item    i_item,
    output logic                  o_valid,
    output aob_pkg::t_div_item    o_item
);
    import aob_pkg::*;

    logic                r_valid;
    t_div_item           r_item;
    t_div_item           n_item;
    logic [DIVR_W:0]     w_trial [NUM_CH];
    logic [DIVR_W:0]     w_diff  [NUM_CH];
    logic [NUM_CH-1:0]   w_bit;

    always_comb begin
        n_item = i_item;
        for (int c = 0; c < NUM_CH; c++) begin
            // Bring the next dividend bit into the partial remainder.
            w_trial[c] = {i_item.ch[c].rem, i_item.ch[c].lq[CH_W-1]};
            w_diff[c]  = w_trial[c] - {1'b0, i_item.divisor};
            w_bit[c]   = (w_trial[c] >= {1'b0, i_item.divisor});
            if (w_bit[c]) begin
                n_item.ch[c].rem = w_diff[c][DIVR_W-1:0];
            end else begin
                n_item.ch[c].rem = w_trial[c][DIVR_W-1:0];
            end
            n_item.ch[c].lq = {i_item.ch[c].lq[CH_W-2:0], w_bit[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/alpha_over_blend_pixel_top.sv
// Top level of the alpha-over pixel blender: stream ports, APB register,
// product stages and the divider pipeline. Depends on aob_pkg and aob_div_step.
//
// Usage: each transfer on s_axis carries a source RGBA pixel and the current
// destination RGBA pixel; one transfer on m_axis returns the new destination
// pixel. Register 0 (blend_mode, address 0) selects replace (0) or
// source-over-destination (1); it resets to 1 and should be written only
// while the pipeline is empty.
// From an accepted input to m_axis_tvalid a pixel passes two product
// stages, one stage that forms the dividend and the output alpha, and eight
// restoring-division steps, one quotient bit per step.
// Throughput is one pixel per cycle while m_axis_tready is high. Each stage has
// its own valid bit and loads whenever it is empty or its successor moves, so a
// stalled m_axis side holds the finished pixel while bubbles further back still
// fill; s_axis_tready drops only when all eleven stages hold a pixel and
// m_axis_tready is low. Reset clears every valid bit and sets blend_mode to 1;
// APB writes take effect at the access cycle and pready is always high.
module alpha_over_blend_pixel_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  logic [aob_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [aob_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aob_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [aob_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [aob_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import aob_pkg::*;

    // Configuration register.
    t_blend_mode     r_blend_mode;
    t_reg_idx        w_reg_idx;

    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= BLEND_OVER;
        end else if (psel && penable && pwrite && pready
                     && (w_reg_idx == REG_BLEND_MODE)) begin
            r_blend_mode <= t_blend_mode'(pwdata[0]);
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_BLEND_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, r_blend_mode};
            default:        prdata = '0;
        endcase
    end

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic [1:NUM_STAGES+1] en;
    logic [1:NUM_STAGES]   v;

    assign en[NUM_STAGES+1] = m_axis_tready;
    for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_en
        assign en[k] = !v[k] || en[k+1];
    end
    assign s_axis_tready = en[1];

    // Input unpacking.
    logic [CH_W-1:0] w_src [NUM_CH];
    logic [CH_W-1:0] w_dst [NUM_CH];
    logic [CH_W-1:0] w_sa;
    logic [CH_W-1:0] w_da;
    logic [CH_W-1:0] w_inv_sa;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_src[c] = s_axis_tdata[c*CH_W +: CH_W];
            w_dst[c] = s_axis_tdata[(c+4)*CH_W +: CH_W];
        end
    end
    assign w_sa     = s_axis_tdata[3*CH_W +: CH_W];
    assign w_da     = s_axis_tdata[7*CH_W +: CH_W];
    assign w_inv_sa = CH_MAX - w_sa;

    // Stage 1: 8x8 products.
    logic                       r1_valid;
    t_blend_mode                r1_mode;
    logic [NUM_CH*CH_W-1:0]     r1_src_rgb;
    logic [CH_W-1:0]            r1_src_a;
    logic [CH_W-1:0]            r1_dst [NUM_CH];
    logic [PROD_W-1:0]          r1_wd;
    logic [PROD_W-1:0]          r1_as;
    logic [PROD_W-1:0]          r1_ps [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en[1]) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_mode    <= r_blend_mode;
            r1_src_rgb <= s_axis_tdata[NUM_CH*CH_W-1:0];
            r1_src_a   <= w_sa;
            r1_wd      <= {{CH_W{1'b0}}, w_da} * {{CH_W{1'b0}}, w_inv_sa};
            r1_as      <= {w_sa, {CH_W{1'b0}}} - {{CH_W{1'b0}}, w_sa};
            for (int c = 0; c < NUM_CH; c++) begin
                r1_dst[c] <= w_dst[c];
                r1_ps[c]  <= {{CH_W{1'b0}}, w_src[c]} * {{CH_W{1'b0}}, w_sa};
            end
        end
    end

    // Stage 2: combined alpha and colour numerators, both scaled by 255.
    logic                       r2_valid;
    t_blend_mode                r2_mode;
    logic [NUM_CH*CH_W-1:0]     r2_src_rgb;
    logic [CH_W-1:0]            r2_src_a;
    logic [PROD_W-1:0]          r2_a;
    logic [NUM_W-1:0]           r2_n [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en[2]) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_mode    <= r1_mode;
            r2_src_rgb <= r1_src_rgb;
            r2_src_a   <= r1_src_a;
            r2_a       <= r1_as + r1_wd;
            for (int c = 0; c < NUM_CH; c++) begin
                r2_n[c] <= ({r1_ps[c], {CH_W{1'b0}}} - {{CH_W{1'b0}}, r1_ps[c]})
                         + ({{PROD_W{1'b0}}, r1_dst[c]} * {{CH_W{1'b0}}, r1_wd});
            end
        end
    end

    // Stage 3: rounding dividend 2N+A over 2A, and alpha = round(A/255).
    // The alpha estimate (x + x/256)/256 is at most one below floor(x/255),
    // so a single compare of the remainder fixes it.
    logic [DIVR_W-1:0]          w_x;
    logic [DIVR_W-1:0]          w_xs;
    logic [CH_W:0]              w_q1;
    logic [DIVR_W-1:0]          w_xr;
    logic [CH_W-1:0]            w_alpha;
    logic [NUM_W:0]             w_dvd [NUM_CH];
    logic                       r3_valid;
    t_div_item                  r3_item;
    t_div_item                  n3_item;

    always_comb begin
        w_x     = {1'b0, r2_a} + DIVR_W'(127);
        w_xs    = w_x + {{CH_W{1'b0}}, w_x[DIVR_W-1:CH_W]};
        w_q1    = w_xs[DIVR_W-1:CH_W];
        w_xr    = w_x - {w_q1, {CH_W{1'b0}}} + {{CH_W{1'b0}}, w_q1};
        w_alpha = w_q1[CH_W-1:0] + {{(CH_W-1){1'b0}}, (w_xr >= DIVR_W'(CH_MAX))};

        n3_item         = '0;
        n3_item.mode    = r2_mode;
        n3_item.a_zero  = (r2_a == '0);
        n3_item.divisor = {r2_a, 1'b0};
        n3_item.src_rgb = r2_src_rgb;
        n3_item.alpha   = (r2_mode == BLEND_OVER) ? w_alpha : r2_src_a;
        for (int c = 0; c < NUM_CH; c++) begin
            w_dvd[c]          = {r2_n[c], 1'b0} + {{(CH_W+1){1'b0}}, r2_a};
            n3_item.ch[c].rem = w_dvd[c][NUM_W:CH_W];
            n3_item.ch[c].lq  = w_dvd[c][CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en[3]) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_item <= n3_item;
        end
    end

    assign v[1] = r1_valid;
    assign v[2] = r2_valid;
    assign v[3] = r3_valid;

    // Stages 4 to 11: one quotient bit per stage.
    t_div_item w_item [PRE_STAGES:NUM_STAGES];

    assign w_item[PRE_STAGES] = r3_item;

    for (genvar k = PRE_STAGES + 1; k <= NUM_STAGES; k++) begin : g_div
        aob_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[k]),
            .i_valid (v[k-1]),
            .i_item  (w_item[k-1]),
            .o_valid (v[k]),
            .o_item  (w_item[k])
        );
    end

    // Output selection from the last stage register.
    t_div_item         w_out;
    logic [CH_W-1:0]   w_col [NUM_CH];

    assign w_out = w_item[NUM_STAGES];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (w_out.mode == BLEND_REPLACE) begin
                w_col[c] = w_out.src_rgb[c*CH_W +: CH_W];
            end else if (w_out.a_zero) begin
                w_col[c] = '0;
            end else begin
                w_col[c] = w_out.ch[c].lq;
            end
        end
    end

    assign m_axis_tvalid = v[NUM_STAGES];
    assign m_axis_tdata  = {w_out.alpha, w_col[2], w_col[1], w_col[0]};

`ifndef NO_ASSERTIONS
    // An empty output stage must let the whole pipeline move.
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output stage is empty");

    // After the last step the remainder of a real division is below the divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_out.mode == BLEND_OVER) && !w_out.a_zero)
        |-> ((w_out.ch[0].rem < w_out.divisor) && (w_out.ch[1].rem < w_out.divisor)
             && (w_out.ch[2].rem < w_out.divisor)))
        else $error("division remainder not below divisor");

    // A fully transparent blend gives an all-zero pixel.
    a_zero_alpha_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_out.mode == BLEND_OVER) && w_out.a_zero)
        |-> (m_axis_tdata == '0))
        else $error("zero combined alpha did not give a zero pixel");

    a_reset_mode: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_blend_mode == BLEND_OVER))
        else $error("blend mode not over after reset");
`endif

endmodule

>>> dv/tb_alpha_over_blend_pixel_top.sv
// Self-checking testbench for the alpha-over pixel blender top level.
// Drives pixels on the input stream, predicts each blended pixel with exact
// integer arithmetic and checks the output stream; depends on aob_pkg and the top level.
module tb_alpha_over_blend_pixel_top;
    import aob_pkg::*;

    localparam int       CLK_HALF      = 5;
    localparam int       RESET_CYCLES  = 9;
    localparam int       PIPE_LATENCY  = 11;
    localparam int       HOLD_CYCLES   = 200;
    localparam int       RUN_LIMIT     = 2_000_000;
    localparam t_reg_idx REG_UNUSED    = 1'b1;

    // Input transfer: the last field sits in the lowest byte of tdata.
    typedef struct packed {
        logic [CH_W-1:0] dst_alpha;
        logic [CH_W-1:0] dst_blue;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] src_alpha;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_red;
    } t_pixel_pair;

    typedef struct packed {
        logic [CH_W-1:0] out_alpha;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
    } t_blended;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_pixel_pair  pixel_q[$];
    t_blended     blended_q[$];
    t_blend_mode  cur_mode       = BLEND_OVER;
    int unsigned  src_idle_pct   = 0;
    int unsigned  sink_stall_pct = 0;
    bit           in_fire        = 1'b0;
    bit           hold_req       = 1'b0;
    bit           holding        = 1'b0;
    int unsigned  err_count      = 0;
    int unsigned  over_count     = 0;
    int unsigned  replace_count  = 0;
    int unsigned  checked_count  = 0;

    alpha_over_blend_pixel_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // out_red, out_green, out_blue, out_alpha
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Colour numerator over the exact combined alpha, rounded with ties up.
    function automatic logic [CH_W-1:0] over_channel(longint unsigned cs, longint unsigned cd,
                                                     longint unsigned sa, longint unsigned da,
                                                     longint unsigned a_sum);
        longint unsigned num;
        longint unsigned quo;
        if (a_sum == 0)
            return '0;
        num = cs * sa * 255 + cd * da * (255 - sa);
        quo = (2 * num + a_sum) / (2 * a_sum);
        if (quo > 255)
            quo = 255;
        return quo[CH_W-1:0];
    endfunction

    function automatic t_blended blend_pixel(t_pixel_pair p, t_blend_mode mode);
        t_blended        r;
        longint unsigned a_sum;
        if (mode == BLEND_REPLACE) begin
            r.out_red   = p.src_red;
            r.out_green = p.src_green;
            r.out_blue  = p.src_blue;
            r.out_alpha = p.src_alpha;
            return r;
        end
        a_sum = longint'(p.src_alpha) * 255 + longint'(p.dst_alpha) * (255 - p.src_alpha);
        r.out_red   = over_channel(p.src_red, p.dst_red, p.src_alpha, p.dst_alpha, a_sum);
        r.out_green = over_channel(p.src_green, p.dst_green, p.src_alpha, p.dst_alpha, a_sum);
        r.out_blue  = over_channel(p.src_blue, p.dst_blue, p.src_alpha, p.dst_alpha, a_sum);
        r.out_alpha = 8'((a_sum + 127) / 255);
        return r;
    endfunction

    function automatic t_pixel_pair make_pair(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                                              logic [7:0] sa, logic [7:0] dr, logic [7:0] dg,
                                              logic [7:0] db, logic [7:0] da);
        t_pixel_pair p;
        p.src_red   = sr;
        p.src_green = sg;
        p.src_blue  = sb;
        p.src_alpha = sa;
        p.dst_red   = dr;
        p.dst_green = dg;
        p.dst_blue  = db;
        p.dst_alpha = da;
        return p;
    endfunction

    // Channels lean toward the extremes so that fully transparent and opaque
    // pixels show up often among the random ones.
    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(7, 0))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic t_pixel_pair rand_pair();
        return make_pair(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                         rand_channel(), rand_channel(), rand_channel(), rand_channel());
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("pixel %0d %s got %0d expected %0d",
                                      checked_count, name, got, want));
    endtask

    // Input driver: holds an offered pixel until it is taken, then picks the
    // next one or leaves a gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (pixel_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !holding && ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // Long output hold-off, counted here so the sender keeps offering pixels.
    always begin
        wait (hold_req);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding  = 1'b0;
        hold_req = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_blended got;
        t_blended want;
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                blended_q.push_back(blend_pixel(t_pixel_pair'(s_axis_tdata), cur_mode));
                void'(pixel_q.pop_front());
                if (cur_mode == BLEND_OVER)
                    over_count++;
                else
                    replace_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_blended'(m_axis_tdata);
                if (blended_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output transfer %h", m_axis_tdata));
                end else begin
                    want = blended_q.pop_front();
                    check_field("out_red", got.out_red, want.out_red);
                    check_field("out_green", got.out_green, want.out_green);
                    check_field("out_blue", got.out_blue, want.out_blue);
                    check_field("out_alpha", got.out_alpha, want.out_alpha);
                end
                checked_count++;
            end
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_BLEND_MODE)
            cur_mode = t_blend_mode'(val[0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_mode();
        logic [APB_DATA_W-1:0] want;
        want = {{(APB_DATA_W-1){1'b0}}, cur_mode};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_BLEND_MODE, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("blend_mode read %h expected %h", prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pixel_q.size() != 0 || blended_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int n, input int unsigned idle_pct,
                              input int unsigned stall_pct, input bit long_hold);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n) pixel_q.push_back(rand_pair());
        if (long_hold)
            hold_req = 1'b1;
        wait_drain();
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_check_mode();

        // Over mode straight out of reset: zero combined alpha, opaque and
        // transparent layers, and colour extremes at partial coverage.
        pixel_q.push_back(make_pair(8'd255, 8'd128, 8'd7, 8'd0, 8'd200, 8'd1, 8'd255, 8'd0));
        pixel_q.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        pixel_q.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255,
                                    8'd255, 8'd255, 8'd255, 8'd255));
        pixel_q.push_back(make_pair(8'd10, 8'd20, 8'd30, 8'd255, 8'd240, 8'd250, 8'd5, 8'd255));
        pixel_q.push_back(make_pair(8'd10, 8'd20, 8'd30, 8'd0, 8'd240, 8'd250, 8'd5, 8'd255));
        pixel_q.push_back(make_pair(8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd128));
        pixel_q.push_back(make_pair(8'd255, 8'd255, 8'd0, 8'd1, 8'd0, 8'd0, 8'd255, 8'd0));
        pixel_q.push_back(make_pair(8'd99, 8'd0, 8'd255, 8'd0, 8'd255, 8'd17, 8'd0, 8'd1));
        pixel_q.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd254, 8'd0, 8'd0, 8'd0, 8'd255));
        pixel_q.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1));
        pixel_q.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));
        pixel_q.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
        pixel_q.push_back(make_pair(8'd128, 8'd127, 8'd129, 8'd127, 8'd127, 8'd128, 8'd1, 8'd128));
        pixel_q.push_back(make_pair(8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0));
        pixel_q.push_back(make_pair(8'd0, 8'd255, 8'd64, 8'd0, 8'd255, 8'd0, 8'd192, 8'd255));
        pixel_q.push_back(make_pair(8'd1, 8'd2, 8'd254, 8'd3, 8'd253, 8'd252, 8'd4, 8'd2));
        wait_drain();

        // Only bit 0 of the written word selects the mode.
        apb_write(REG_BLEND_MODE, 32'hFFFF_FFFE);
        apb_check_mode();
        pixel_q.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
        pixel_q.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0));
        pixel_q.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));
        wait_drain();

        // A write to an index with no register behind it must not change the mode.
        apb_write(REG_UNUSED, 32'h0000_0001);
        apb_check_mode();
        pixel_q.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
        pixel_q.push_back(make_pair(8'd12, 8'd34, 8'd56, 8'd0, 8'd78, 8'd90, 8'd11, 8'd0));
        wait_drain();

        apb_write(REG_BLEND_MODE, 32'h0000_0001);
        apb_check_mode();
        run_random(250, 0, 0, 1'b1);
        run_random(250, 59, 0, 1'b0);
        apb_write(REG_BLEND_MODE, 32'h0000_0000);
        apb_check_mode();
        run_random(200, 0, 59, 1'b0);
        apb_write(REG_BLEND_MODE, 32'h8000_0001);
        apb_check_mode();
        run_random(250, 8, 8, 1'b0);

        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d blended pixels: %0d in over mode, %0d in replace mode,",
                 checked_count, over_count, replace_count);
        $display("under free-running, bursty-input, stalled-output and mixed pacing.");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", err_count);
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT;
        $display("Run limit reached with %0d pixels outstanding", blended_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
